// ===== hw/rtl/lsmc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsmc_pkg: shared types and constants for light sphere mask culling
// Field widths, item structs, table entry struct and sequencer codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lsmc_pkg;

  // Field widths
  localparam int COORD_BITS     = 32;
  localparam int RAD_BITS       = COORD_BITS - 1;
  localparam int MASK_BITS      = 32;
  localparam int IDX_BITS       = 5;
  localparam int CNT_BITS       = 6;
  localparam int MAX_LIGHTS_DEF = 32;

  // Item operations
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_DONE
  } state_e;

  // Input item
  typedef struct packed {
    op_e                          opcode;
    logic [IDX_BITS-1:0]          light_index;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic [RAD_BITS-1:0]          sphere_radius;
    logic                         surface_lightable;
    logic [MASK_BITS-1:0]         candidate_mask;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [MASK_BITS-1:0] lit_mask;
    logic                 any_lit;
  } out_item_t;

  // One sphere: table entry or surface bound
  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
    logic [RAD_BITS-1:0]          radius;
  } sphere_t;

  // Table port strobes from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lsmc_light_ram.sv =====
// ----------------------------------------------------------------------------
// lsmc_light_ram: light sphere table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lsmc_light_ram #(
  parameter int DEPTH = lsmc_pkg::MAX_LIGHTS_DEF,
  parameter int AW    = 5
) (
  input  wire logic               clk_i,
  input  wire lsmc_pkg::ram_req_t req_i,
  input  wire logic [AW-1:0]      wr_addr_i,
  input  wire lsmc_pkg::sphere_t  wr_data_i,
  input  wire logic [AW-1:0]      rd_addr_i,
  output lsmc_pkg::sphere_t       rd_data_o
);

  lsmc_pkg::sphere_t mem_q [DEPTH];
  lsmc_pkg::sphere_t rd_data_q;

  // Store one entry
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Fetch one entry
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lsmc_box_test.sv =====
// ----------------------------------------------------------------------------
// lsmc_box_test: shared sphere box overlap unit
// Flags a miss when the boxes around two spheres are apart on any axis.
// ----------------------------------------------------------------------------
`default_nettype none

module lsmc_box_test (
  input  wire lsmc_pkg::sphere_t surf_i,
  input  wire lsmc_pkg::sphere_t light_i,
  output logic                   miss_o
);

  localparam int CB = lsmc_pkg::COORD_BITS;
  localparam int W  = CB + 1;

  logic signed [W-1:0] s_c  [3];
  logic signed [W-1:0] l_c  [3];
  logic signed [W-1:0] s_r;
  logic signed [W-1:0] l_r;
  logic signed [W-1:0] s_hi [3];
  logic signed [W-1:0] s_lo [3];
  logic signed [W-1:0] l_hi [3];
  logic signed [W-1:0] l_lo [3];
  logic [2:0]          ax_miss;

  // Widen by one bit so no sum can overflow
  assign s_c[0] = {surf_i.cx[CB-1], surf_i.cx};
  assign s_c[1] = {surf_i.cy[CB-1], surf_i.cy};
  assign s_c[2] = {surf_i.cz[CB-1], surf_i.cz};
  assign l_c[0] = {light_i.cx[CB-1], light_i.cx};
  assign l_c[1] = {light_i.cy[CB-1], light_i.cy};
  assign l_c[2] = {light_i.cz[CB-1], light_i.cz};
  assign s_r    = {2'b00, surf_i.radius};
  assign l_r    = {2'b00, light_i.radius};

  // Compare box extents per axis; touching counts as a hit
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s_hi[a]    = s_c[a] + s_r;
      s_lo[a]    = s_c[a] - s_r;
      l_hi[a]    = l_c[a] + l_r;
      l_lo[a]    = l_c[a] - l_r;
      ax_miss[a] = (s_hi[a] < l_lo[a]) || (s_lo[a] > l_hi[a]);
    end
  end

  assign miss_o = |ax_miss;

endmodule

`default_nettype wire

// ===== hw/rtl/lsmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsmc_ctrl: item sequencer
// Takes items, walks the light table one entry a cycle, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lsmc_ctrl #(
  parameter int MAX_LIGHTS = lsmc_pkg::MAX_LIGHTS_DEF,
  parameter int AW         = 5
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire lsmc_pkg::in_item_t             in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output lsmc_pkg::out_item_t                 out_data_o,
  input  wire logic [lsmc_pkg::CNT_BITS-1:0]  eff_count_i,
  output lsmc_pkg::ram_req_t                  ram_req_o,
  output logic [AW-1:0]                       wr_addr_o,
  output lsmc_pkg::sphere_t                   wr_data_o,
  output logic [AW-1:0]                       rd_addr_o,
  output lsmc_pkg::sphere_t                   surf_o,
  input  wire logic                           miss_i
);

  localparam int MW = lsmc_pkg::MASK_BITS;
  localparam int CW = lsmc_pkg::CNT_BITS;

  lsmc_pkg::state_e    state_q, state_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [AW-1:0]       last_q, last_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       pend_idx_q, pend_idx_d;
  logic [MW-1:0]       mask_q, mask_d;
  lsmc_pkg::sphere_t   surf_q;
  logic                out_valid_q, out_valid_d;
  lsmc_pkg::out_item_t out_data_q, out_data_d;
  logic                in_acc;
  logic                idx_ok;
  logic [CW-1:0]       last_full;
  logic [MW-1:0]       bit_sel;

  assign in_acc    = in_valid_i && in_ready_o;
  assign idx_ok    = {1'b0, in_data_i.light_index} < CW'(MAX_LIGHTS);
  assign last_full = eff_count_i - CW'(1);
  assign bit_sel   = {{(MW-1){1'b0}}, 1'b1} << pend_idx_q;

  // Table write data and addresses
  assign wr_addr_o = in_data_i.light_index[AW-1:0];
  assign wr_data_o = '{cx:     in_data_i.center_x,
                       cy:     in_data_i.center_y,
                       cz:     in_data_i.center_z,
                       radius: in_data_i.sphere_radius};
  assign rd_addr_o = idx_q;
  assign surf_o    = surf_q;

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    last_d      = last_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    in_ready_o  = 1'b0;
    ram_req_o   = '0;

    // Drop the bit of a light whose box misses
    if (pend_q && miss_i) begin
      mask_d = mask_q & ~bit_sel;
    end

    case (state_q)
      lsmc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_data_i.opcode == lsmc_pkg::OP_WRITE) begin
            ram_req_o.wr_en = idx_ok;
          end else if (in_data_i.surface_lightable && (eff_count_i != '0)) begin
            mask_d  = in_data_i.candidate_mask;
            idx_d   = '0;
            last_d  = last_full[AW-1:0];
            state_d = lsmc_pkg::ST_WALK;
          end else begin
            mask_d  = in_data_i.surface_lightable ? in_data_i.candidate_mask : '0;
            state_d = lsmc_pkg::ST_DONE;
          end
        end
      end
      lsmc_pkg::ST_WALK: begin
        ram_req_o.rd_en = 1'b1;
        pend_d          = 1'b1;
        pend_idx_d      = idx_q;
        if (idx_q == last_q) begin
          state_d = lsmc_pkg::ST_FLUSH;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      lsmc_pkg::ST_FLUSH: begin
        state_d = lsmc_pkg::ST_DONE;
      end
      lsmc_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_data_d.lit_mask = mask_q;
          out_data_d.any_lit  = |mask_q;
          state_d             = lsmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lsmc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsmc_pkg::ST_IDLE;
      idx_q       <= '0;
      last_q      <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mask_q     <= mask_d;
    out_data_q <= out_data_d;
    if (in_acc && (in_data_i.opcode == lsmc_pkg::OP_QUERY)) begin
      surf_q <= wr_data_o;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/light_sphere_mask_cull_top.sv =====
// ----------------------------------------------------------------------------
// light_sphere_mask_cull_top: dynamic light culling by sphere bounding boxes
// Light table, light count register, sequencer and shared box test unit.
// ----------------------------------------------------------------------------
// A write item stores one light sphere and leaves the block ready. A query
// item keeps the block busy while it walks n table entries, where n is the
// light count clamped to MAX_LIGHTS, then flushes and hands over its result;
// an unlightable surface or a count of zero skips the walk. The walk reads
// one entry per cycle through the single read port and tests it in the one
// shared box test unit. The result sits in an output register, so a query
// may finish while the previous result still waits. Entries must be written
// before a query tests them. Write light_count only while the block is idle.
`default_nettype none

module light_sphere_mask_cull_top #(
  parameter int MAX_LIGHTS = lsmc_pkg::MAX_LIGHTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire lsmc_pkg::in_item_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output lsmc_pkg::out_item_t                out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lsmc_pkg::CNT_BITS-1:0] cfg_data_i
);

  localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int CW = lsmc_pkg::CNT_BITS;

  logic [CW-1:0]      light_count_q;
  logic [CW-1:0]      eff_count;
  lsmc_pkg::ram_req_t ram_req;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  lsmc_pkg::sphere_t  wr_data;
  lsmc_pkg::sphere_t  rd_data;
  lsmc_pkg::sphere_t  surf;
  logic               miss;

  // Light count register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      light_count_q <= cfg_data_i;
    end
  end

  // Clamp the count to the table depth
  assign eff_count = (light_count_q > CW'(MAX_LIGHTS)) ? CW'(MAX_LIGHTS) : light_count_q;

  lsmc_ctrl #(
    .MAX_LIGHTS (MAX_LIGHTS),
    .AW         (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .eff_count_i (eff_count),
    .ram_req_o   (ram_req),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr),
    .surf_o      (surf),
    .miss_i      (miss)
  );

  lsmc_light_ram #(
    .DEPTH (MAX_LIGHTS),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  lsmc_box_test u_box (
    .surf_i  (surf),
    .light_i (rd_data),
    .miss_o  (miss)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/lsmc_checker.sv =====
// ----------------------------------------------------------------------------
// lsmc_checker: port-level checks for light sphere mask culling
// Watches the top level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsmc_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_o,
  input  wire lsmc_pkg::in_item_t            in_data_i,
  input  wire logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  input  wire lsmc_pkg::out_item_t           out_data_o
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // Flag must agree with the mask
  a_any_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.any_lit == (out_data_o.lit_mask != '0)))
    else $error("any_lit disagrees with lit_mask");

  // A write item leaves the block ready at once
  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.opcode == lsmc_pkg::OP_WRITE) |=> in_ready_o)
    else $error("block busy after a write item");

  // A query item makes the block busy
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.opcode == lsmc_pkg::OP_QUERY) |=> !in_ready_o)
    else $error("block ready right after a query item");

  // An unlightable surface, with no result waiting, yields an empty mask
  a_unlit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.opcode == lsmc_pkg::OP_QUERY) && !in_data_i.surface_lightable
      && !out_valid_o |-> ##2 (out_valid_o && (out_data_o.lit_mask == '0)))
    else $error("unlightable surface gave no empty result");

endmodule

bind light_sphere_mask_cull_top lsmc_checker u_lsmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
